### rtl/circle_column_point_generator_assert.svh
// Assertion macros shared by the checker of the circle column point generator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef CIRCLE_COLUMN_POINT_GENERATOR_ASSERT_SVH
`define CIRCLE_COLUMN_POINT_GENERATOR_ASSERT_SVH

// Overlapping implication: when ante holds at an edge, cons must hold at that edge.
`define CCPG_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds at an edge, cons must hold at the next edge.
`define CCPG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ccpg_pkg.sv
// Types, constants and the square-root step shared by the circle column point generator.
// Depends on nothing; all RTL files but the assertion header use its scoped names.
`timescale 1ns / 1ps

package ccpg_pkg;

   // Field widths.
   localparam int COORD_W  = 11;
   localparam int POS_W    = 12;
   localparam int RADIUS_W = 10;
   localparam int COLUMN_W = 10;
   localparam int SQ_W     = 20;
   localparam int RES_W    = 21;
   localparam int ROOT_W   = 10;
   localparam int VY_W     = 11;
   localparam int LIMIT_W  = 11;

   // Reciprocal of 1.414 in 0.24 fixed point, and the rounding half.
   localparam int PROD_W      = 34;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_MUL  = 24'd11865075;
   localparam logic [PROD_W:0]    RECIP_HALF = 35'd8388608;

   // Square root: ten digit steps, two per pipeline stage.
   localparam int SQRT_STEPS  = 10;
   localparam int SQRT_STAGES = 5;

   // Front pipeline depth: products, setup, root stages, rounding.
   localparam int FRONT_STAGES = SQRT_STAGES + 3;
   localparam int INFLIGHT_W   = 4;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_W = 4;
   localparam int QUEUE_CNT_W = 5;
   localparam int OCC_W       = 6;

   // One item in flight through the root pipeline.
   typedef struct packed {
      logic signed [COORD_W-1:0] ox;
      logic signed [COORD_W-1:0] oy;
      logic [COLUMN_W-1:0]       vx;
      logic                      in_range;
      logic                      last_col;
      logic [SQ_W-1:0]           rem;
      logic [RES_W-1:0]          res;
   } ccpg_work_type;

   // One classified item waiting in the queue.
   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] neg_x;
      logic signed [POS_W-1:0] neg_y;
      logic                    in_range;
      logic                    last_col;
   } ccpg_entry_type;

   // Queue status seen by the back end and the top level.
   typedef struct packed {
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } ccpg_fifo_status_type;

   // Back end: which result of the head transaction goes out next.
   typedef enum logic {
      PHASE_PLAIN,
      PHASE_SWAP
   } ccpg_phase_type;

   // One digit step of the integer square root.
   function automatic ccpg_work_type sqrt_step(input ccpg_work_type w,
                                               input logic [RES_W-1:0] bit_val);
      logic [RES_W-1:0] trial;
      ccpg_work_type    o;
      o     = w;
      trial = w.res + bit_val;
      if ({1'b0, w.rem} >= trial) begin
         o.rem = w.rem - trial[SQ_W-1:0];
         o.res = (w.res >> 1) + bit_val;
      end else begin
         o.res = w.res >> 1;
      end
      return o;
   endfunction

endpackage

### rtl/circle_column_point_generator.sv
// Top level of the circle column point generator: front end, queue and back end.
// Depends on ccpg_pkg, ccpg_front, ccpg_fifo and ccpg_back.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_center_x/y, req_radius, req_column
// result    out        rsp_strobe, one cycle     rsp_a/b_pos, rsp_a/b_neg, rsp_swapped,
//                                                rsp_in_range, rsp_last, rsp_last_column
//
// A transaction passes through the front pipeline (products, limit setup, five two-digit
// square-root stages, rounding) and then waits in a 16-entry queue.
// The single result port sets the rate: two results per in-range column, one otherwise.
// busy rises when the front pipeline and the queue together hold 16 transactions.
// The receiver cannot stall; every result holds the port for one cycle only.
// Reset is synchronous and empties the pipeline and the queue; there is no clearing pass.
`timescale 1ns / 1ps

module circle_column_point_generator #(
   parameter int MAX_RADIUS = 1023
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ccpg_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ccpg_pkg::COORD_W-1:0] req_center_y,
   input  logic [ccpg_pkg::RADIUS_W-1:0]       req_radius,
   input  logic [ccpg_pkg::COLUMN_W-1:0]       req_column,
   output logic                                rsp_strobe,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_a_pos,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_b_pos,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_a_neg,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_b_neg,
   output logic                                rsp_swapped,
   output logic                                rsp_in_range,
   output logic                                rsp_last,
   output logic                                rsp_last_column
);

   logic                                   take;
   logic                                   push;
   logic                                   pop;
   ccpg_pkg::ccpg_entry_type               push_data;
   ccpg_pkg::ccpg_entry_type               head_data;
   ccpg_pkg::ccpg_fifo_status_type         status;
   logic [ccpg_pkg::INFLIGHT_W-1:0]        inflight;
   logic [ccpg_pkg::OCC_W-1:0]             occupancy;

   // Credit check: every transaction in the front has a queue slot reserved.
   assign occupancy = ccpg_pkg::OCC_W'(inflight) + ccpg_pkg::OCC_W'(status.count);
   assign busy      = (occupancy >= ccpg_pkg::OCC_W'(ccpg_pkg::QUEUE_DEPTH));
   assign take      = start && !busy;

   ccpg_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .center_x  (req_center_x),
      .center_y  (req_center_y),
      .radius    (req_radius),
      .column    (req_column),
      .push      (push),
      .push_data (push_data),
      .inflight  (inflight)
   );

   ccpg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (status)
   );

   ccpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_data       (head_data),
      .status          (status),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_a_pos       (rsp_a_pos),
      .rsp_b_pos       (rsp_b_pos),
      .rsp_a_neg       (rsp_a_neg),
      .rsp_b_neg       (rsp_b_neg),
      .rsp_swapped     (rsp_swapped),
      .rsp_in_range    (rsp_in_range),
      .rsp_last        (rsp_last),
      .rsp_last_column (rsp_last_column)
   );

endmodule

### rtl/ccpg_fifo.sv
// Short queue of classified transactions between the front and back ends.
// Depends on ccpg_pkg for the entry and status types.
`timescale 1ns / 1ps

module ccpg_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ccpg_pkg::ccpg_entry_type       push_data,
   input  logic                           pop,
   output ccpg_pkg::ccpg_entry_type       head_data,
   output ccpg_pkg::ccpg_fifo_status_type status
);

   ccpg_pkg::ccpg_entry_type               entry_ff [ccpg_pkg::QUEUE_DEPTH];
   logic [ccpg_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff;
   logic [ccpg_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff;
   logic [ccpg_pkg::QUEUE_CNT_W-1:0]       count_ff;
   logic [ccpg_pkg::QUEUE_CNT_W-1:0]       count_in;

   // Storage is written at the tail; it needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers wrap naturally at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

### rtl/ccpg_front.sv
// Front end: takes a transaction, finds the column limit and the rounded column height.
// Depends on ccpg_pkg for widths, the reciprocal constant and the root step.
`timescale 1ns / 1ps

module ccpg_front #(
   parameter int MAX_RADIUS = 1023
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic signed [ccpg_pkg::COORD_W-1:0]   center_x,
   input  logic signed [ccpg_pkg::COORD_W-1:0]   center_y,
   input  logic [ccpg_pkg::RADIUS_W-1:0]         radius,
   input  logic [ccpg_pkg::COLUMN_W-1:0]         column,
   output logic                                  push,
   output ccpg_pkg::ccpg_entry_type              push_data,
   output logic [ccpg_pkg::INFLIGHT_W-1:0]       inflight
);

   localparam int RW = ccpg_pkg::RADIUS_W;

   logic [ccpg_pkg::RADIUS_W-1:0]     r_sat;
   logic [ccpg_pkg::SQ_W-1:0]         rsq;
   logic [ccpg_pkg::SQ_W-1:0]         vsq;
   logic [ccpg_pkg::PROD_W-1:0]       prod;

   logic                              p1_valid_ff;
   logic signed [ccpg_pkg::COORD_W-1:0] p1_ox_ff;
   logic signed [ccpg_pkg::COORD_W-1:0] p1_oy_ff;
   logic [ccpg_pkg::COLUMN_W-1:0]     p1_vx_ff;
   logic [ccpg_pkg::SQ_W-1:0]         p1_rsq_ff;
   logic [ccpg_pkg::SQ_W-1:0]         p1_vsq_ff;
   logic [ccpg_pkg::PROD_W-1:0]       p1_prod_ff;

   logic [ccpg_pkg::PROD_W:0]         round_sum;
   logic [ccpg_pkg::LIMIT_W-1:0]      limit;
   logic [ccpg_pkg::LIMIT_W-1:0]      vx_wide;
   ccpg_pkg::ccpg_work_type           setup;
   logic                              p2_valid_ff;
   ccpg_pkg::ccpg_work_type           p2_work_ff;

   logic                              root_valid_ff [ccpg_pkg::SQRT_STAGES];
   ccpg_pkg::ccpg_work_type           root_work_ff  [ccpg_pkg::SQRT_STAGES];
   ccpg_pkg::ccpg_work_type           root_in       [ccpg_pkg::SQRT_STAGES];
   ccpg_pkg::ccpg_work_type           root_out      [ccpg_pkg::SQRT_STAGES];
   logic                              root_in_valid [ccpg_pkg::SQRT_STAGES];

   ccpg_pkg::ccpg_work_type           fin;
   logic [ccpg_pkg::ROOT_W-1:0]       root;
   logic [ccpg_pkg::VY_W-1:0]         vy;
   ccpg_pkg::ccpg_entry_type          entry;
   logic                              p3_valid_ff;
   ccpg_pkg::ccpg_entry_type          p3_entry_ff;

   logic [ccpg_pkg::INFLIGHT_W-1:0]   inflight_ff;
   logic [ccpg_pkg::INFLIGHT_W-1:0]   inflight_in;

   // Radius saturation and the three products, taken straight from the request.
   assign r_sat = (int'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius;
   assign rsq   = r_sat * r_sat;
   assign vsq   = column * column;
   assign prod  = r_sat * ccpg_pkg::RECIP_MUL;

   always_ff @(posedge clock) begin
      p1_ox_ff   <= center_x;
      p1_oy_ff   <= center_y;
      p1_vx_ff   <= column;
      p1_rsq_ff  <= rsq;
      p1_vsq_ff  <= vsq;
      p1_prod_ff <= prod;
   end

   // Rounded column limit, range test and the square-root operand.
   always_comb begin
      round_sum      = {1'b0, p1_prod_ff} + ccpg_pkg::RECIP_HALF;
      limit          = round_sum[ccpg_pkg::PROD_W:ccpg_pkg::RECIP_SHIFT] + 1'b1;
      vx_wide        = {1'b0, p1_vx_ff};
      setup.ox       = p1_ox_ff;
      setup.oy       = p1_oy_ff;
      setup.vx       = p1_vx_ff;
      setup.in_range = (vx_wide < limit);
      setup.last_col = ((vx_wide + 1'b1) == limit);
      setup.rem      = (p1_rsq_ff >= p1_vsq_ff) ? (p1_rsq_ff - p1_vsq_ff) : '0;
      setup.res      = '0;
   end

   always_ff @(posedge clock) begin
      p2_work_ff <= setup;
   end

   // Root pipeline: each stage resolves two digits of the floor square root.
   always_comb begin
      for (int j = 0; j < ccpg_pkg::SQRT_STAGES; j++) begin
         if (j == 0) begin
            root_in[j]       = p2_work_ff;
            root_in_valid[j] = p2_valid_ff;
         end else begin
            root_in[j]       = root_work_ff[j-1];
            root_in_valid[j] = root_valid_ff[j-1];
         end
         root_out[j] = ccpg_pkg::sqrt_step(
            ccpg_pkg::sqrt_step(root_in[j],
               ccpg_pkg::RES_W'(1) << (2 * (ccpg_pkg::SQRT_STEPS - 1 - 2 * j))),
            ccpg_pkg::RES_W'(1) << (2 * (ccpg_pkg::SQRT_STEPS - 2 - 2 * j)));
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ccpg_pkg::SQRT_STAGES; j++) begin
         root_work_ff[j] <= root_out[j];
      end
   end

   // Round to nearest: the remainder above the root means n > s*s + s.
   always_comb begin
      fin            = root_work_ff[ccpg_pkg::SQRT_STAGES-1];
      root           = fin.res[ccpg_pkg::ROOT_W-1:0];
      vy             = {1'b0, root} +
                       ((fin.rem > {{(ccpg_pkg::SQ_W - ccpg_pkg::ROOT_W){1'b0}}, root}) ?
                        ccpg_pkg::VY_W'(1) : ccpg_pkg::VY_W'(0));
      entry.pos_x    = {fin.ox[ccpg_pkg::COORD_W-1], fin.ox} + {2'b00, fin.vx};
      entry.neg_x    = {fin.ox[ccpg_pkg::COORD_W-1], fin.ox} - {2'b00, fin.vx};
      entry.pos_y    = {fin.oy[ccpg_pkg::COORD_W-1], fin.oy} + {1'b0, vy};
      entry.neg_y    = {fin.oy[ccpg_pkg::COORD_W-1], fin.oy} - {1'b0, vy};
      entry.in_range = fin.in_range;
      entry.last_col = fin.last_col;
   end

   always_ff @(posedge clock) begin
      p3_entry_ff <= entry;
   end

   // Count of transactions inside the front pipeline.
   always_comb begin
      inflight_in = inflight_ff;
      if (take && !p3_valid_ff) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (p3_valid_ff && !take) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   // Stage valid bits and the in-flight count.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         inflight_ff <= '0;
         for (int j = 0; j < ccpg_pkg::SQRT_STAGES; j++) begin
            root_valid_ff[j] <= 1'b0;
         end
      end else begin
         p1_valid_ff <= take;
         p2_valid_ff <= p1_valid_ff;
         for (int j = 0; j < ccpg_pkg::SQRT_STAGES; j++) begin
            root_valid_ff[j] <= root_in_valid[j];
         end
         p3_valid_ff <= root_valid_ff[ccpg_pkg::SQRT_STAGES-1];
         inflight_ff <= inflight_in;
      end
   end

   assign push      = p3_valid_ff;
   assign push_data = p3_entry_ff;
   assign inflight  = inflight_ff;

endmodule

### rtl/ccpg_back.sv
// Back end: turns each queued transaction into one or two registered results.
// Depends on ccpg_pkg for the entry, status and phase types.
`timescale 1ns / 1ps

module ccpg_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ccpg_pkg::ccpg_entry_type            head_data,
   input  ccpg_pkg::ccpg_fifo_status_type      status,
   output logic                                pop,
   output logic                                rsp_strobe,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_a_pos,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_b_pos,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_a_neg,
   output logic signed [ccpg_pkg::POS_W-1:0]   rsp_b_neg,
   output logic                                rsp_swapped,
   output logic                                rsp_in_range,
   output logic                                rsp_last,
   output logic                                rsp_last_column
);

   ccpg_pkg::ccpg_phase_type            state_ff;
   ccpg_pkg::ccpg_phase_type            state_in;

   logic                                emit;
   logic signed [ccpg_pkg::POS_W-1:0]   a_pos_in;
   logic signed [ccpg_pkg::POS_W-1:0]   b_pos_in;
   logic signed [ccpg_pkg::POS_W-1:0]   a_neg_in;
   logic signed [ccpg_pkg::POS_W-1:0]   b_neg_in;
   logic                                swapped_in;
   logic                                in_range_in;
   logic                                last_in;
   logic                                last_column_in;

   logic                                strobe_ff;
   logic signed [ccpg_pkg::POS_W-1:0]   a_pos_ff;
   logic signed [ccpg_pkg::POS_W-1:0]   b_pos_ff;
   logic signed [ccpg_pkg::POS_W-1:0]   a_neg_ff;
   logic signed [ccpg_pkg::POS_W-1:0]   b_neg_ff;
   logic                                swapped_ff;
   logic                                in_range_ff;
   logic                                last_ff;
   logic                                last_column_ff;

   // Next phase: an in-range head needs a second, swapped result.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccpg_pkg::PHASE_PLAIN: begin
            if (!status.empty && head_data.in_range) begin
               state_in = ccpg_pkg::PHASE_SWAP;
            end
         end
         ccpg_pkg::PHASE_SWAP: begin
            state_in = ccpg_pkg::PHASE_PLAIN;
         end
         default: begin
            state_in = ccpg_pkg::PHASE_PLAIN;
         end
      endcase
   end

   // Result selection and queue pop for the current phase.
   always_comb begin
      emit           = !status.empty;
      pop            = 1'b0;
      a_pos_in       = '0;
      b_pos_in       = '0;
      a_neg_in       = '0;
      b_neg_in       = '0;
      swapped_in     = 1'b0;
      in_range_in    = 1'b0;
      last_in        = 1'b1;
      last_column_in = 1'b0;
      case (state_ff)
         ccpg_pkg::PHASE_PLAIN: begin
            if (head_data.in_range) begin
               a_pos_in       = head_data.pos_x;
               b_pos_in       = head_data.pos_y;
               a_neg_in       = head_data.neg_x;
               b_neg_in       = head_data.neg_y;
               in_range_in    = 1'b1;
               last_in        = 1'b0;
               last_column_in = head_data.last_col;
            end else begin
               pop = !status.empty;
            end
         end
         ccpg_pkg::PHASE_SWAP: begin
            pop            = 1'b1;
            a_pos_in       = head_data.pos_y;
            b_pos_in       = head_data.pos_x;
            a_neg_in       = head_data.neg_y;
            b_neg_in       = head_data.neg_x;
            swapped_in     = 1'b1;
            in_range_in    = 1'b1;
            last_column_in = head_data.last_col;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Control state and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ccpg_pkg::PHASE_PLAIN;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= emit;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      a_pos_ff       <= a_pos_in;
      b_pos_ff       <= b_pos_in;
      a_neg_ff       <= a_neg_in;
      b_neg_ff       <= b_neg_in;
      swapped_ff     <= swapped_in;
      in_range_ff    <= in_range_in;
      last_ff        <= last_in;
      last_column_ff <= last_column_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_a_pos       = a_pos_ff;
   assign rsp_b_pos       = b_pos_ff;
   assign rsp_a_neg       = a_neg_ff;
   assign rsp_b_neg       = b_neg_ff;
   assign rsp_swapped     = swapped_ff;
   assign rsp_in_range    = in_range_ff;
   assign rsp_last        = last_ff;
   assign rsp_last_column = last_column_ff;

endmodule

### rtl/ccpg_checker.sv
// Port-level checker for the circle column point generator, bound to the top level.
// Depends on circle_column_point_generator_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "circle_column_point_generator_assert.svh"

module ccpg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_strobe,
   input logic signed [ccpg_pkg::POS_W-1:0]   rsp_a_pos,
   input logic signed [ccpg_pkg::POS_W-1:0]   rsp_b_pos,
   input logic                                rsp_swapped,
   input logic                                rsp_in_range,
   input logic                                rsp_last_column
);

   // A plain in-range result is always followed at once by its swapped partner.
   `CCPG_ASSERT_NEXT(a_plain_then_swap, clock, reset, rsp_strobe && rsp_in_range && !rsp_swapped, rsp_strobe && rsp_swapped, "plain result not followed by swapped result")

   // A swapped result never appears without the plain result just before it.
   `CCPG_ASSERT_IMPLY(a_swap_after_plain, clock, reset, rsp_strobe && rsp_swapped, $past(rsp_strobe && rsp_in_range && !rsp_swapped), "swapped result without preceding plain result")

   // The swapped result mirrors the positive coordinates of its plain partner and keeps its last-column flag.
   `CCPG_ASSERT_IMPLY(a_swap_mirrors, clock, reset, rsp_strobe && rsp_swapped, rsp_a_pos == $past(rsp_b_pos) && rsp_b_pos == $past(rsp_a_pos) && rsp_last_column == $past(rsp_last_column), "swapped result does not mirror plain result")

endmodule

bind circle_column_point_generator ccpg_checker u_ccpg_checker (.*);
